[src/salru_pkg.sv]
package salru_pkg;

   localparam int SETS             = 256;
   localparam int WAYS             = 8;
   localparam int ADDR_BITS        = 48;
   localparam int LINE_OFFSET_BITS = 6;

   // SETS is a power of two: the set is a plain field of the line number
   localparam int SET_BITS  = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WAY_BITS  = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int RANK_BITS = WAY_BITS;
   localparam int TAG_BITS  = ADDR_BITS - LINE_OFFSET_BITS - SET_BITS;

   localparam int OUT_WAY_BITS = 3;
   localparam int COUNT_BITS   = 32;

   typedef logic [SET_BITS-1:0]                 salru_set_type;
   typedef logic [TAG_BITS-1:0]                 salru_tag_type;
   typedef logic [WAY_BITS-1:0]                 salru_way_type;
   typedef logic [WAYS-1:0]                     salru_valid_type;
   typedef logic [WAYS-1:0][RANK_BITS-1:0]      salru_rank_type;
   typedef logic [WAYS-1:0][TAG_BITS-1:0]       salru_tags_type;

   typedef struct packed {
      salru_set_type set_idx;
      salru_tag_type tag;
   } salru_req_type;

   typedef struct packed {
      salru_valid_type valid;
      salru_rank_type  rank;
   } salru_meta_type;

   // rank of a never-touched set: rank equals way number
   function automatic salru_rank_type rank_reset();
      salru_rank_type r;
      for (int w = 0; w < WAYS; w++) begin
         r[w] = RANK_BITS'(w);
      end
      return r;
   endfunction

endpackage

[src/salru_front.sv]
module salru_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [47:0]            req_address,
   output logic                   push_valid,
   input  logic                   push_ready,
   output salru_pkg::salru_req_type push_data
);
   import salru_pkg::*;

   logic          front_valid_ff;
   salru_req_type front_data_ff;
   salru_req_type front_data_in;
   logic [ADDR_BITS-LINE_OFFSET_BITS-1:0] line_num;

   assign line_num = req_address[ADDR_BITS-1:LINE_OFFSET_BITS];

   always_comb begin
      front_data_in.set_idx = line_num[SET_BITS-1:0];
      front_data_in.tag     = line_num[ADDR_BITS-LINE_OFFSET_BITS-1:SET_BITS];
   end

   assign req_ready  = !front_valid_ff || push_ready;
   assign push_valid = front_valid_ff;
   assign push_data  = front_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else if (req_ready) begin
         front_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         front_data_ff <= front_data_in;
      end
   end

endmodule

[src/salru_queue.sv]
module salru_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  salru_pkg::salru_req_type push_data,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output salru_pkg::salru_req_type pop_data
);
   import salru_pkg::*;

   salru_req_type slot_ff [2];
   logic          wr_ptr_ff;
   logic          rd_ptr_ff;
   logic [1:0]    count_ff;
   logic          push_fire;
   logic          pop_fire;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push_fire) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop_fire) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         case ({push_fire, pop_fire})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[src/salru_back.sv]
module salru_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     pop_valid,
   output logic                     pop_ready,
   input  salru_pkg::salru_req_type pop_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_hit,
   output logic [2:0]               rsp_way_used,
   output logic [31:0]              rsp_hit_count,
   output logic [31:0]              rsp_miss_count
);
   import salru_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_RESOLVE
   } state_type;

   state_type       state_ff;
   salru_req_type   cur_ff;
   logic            rsp_valid_ff;
   logic            rsp_hit_ff;
   logic [OUT_WAY_BITS-1:0] rsp_way_ff;
   logic [COUNT_BITS-1:0]   hit_count_ff;
   logic [COUNT_BITS-1:0]   miss_count_ff;
   logic [COUNT_BITS-1:0]   hit_count_in;
   logic [COUNT_BITS-1:0]   miss_count_in;

   salru_tags_type  tag_mem [SETS];
   salru_meta_type  meta_mem [SETS];
   logic            row_init_ff [SETS];
   salru_tags_type  tags_rd_ff;
   salru_meta_type  meta_rd_ff;
   logic            init_rd_ff;

   salru_valid_type valid_cur;
   salru_rank_type  rank_cur;
   salru_valid_type hit_vec;
   salru_valid_type rank0_vec;
   logic            hit;
   logic            any_free;
   salru_way_type   hit_way;
   salru_way_type   free_way;
   salru_way_type   lru_way;
   salru_way_type   way_sel;
   logic [RANK_BITS-1:0] old_rank;
   salru_tags_type  tags_in;
   salru_meta_type  meta_in;

   logic pop_fire;
   logic out_free;
   logic commit;

   assign pop_ready = (state_ff == ST_IDLE);
   assign pop_fire  = pop_valid && pop_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign commit    = (state_ff == ST_RESOLVE) && out_free;

   // look up the set row read when the request was popped; a row never written reads as reset state
   always_comb begin
      valid_cur = init_rd_ff ? meta_rd_ff.valid : '0;
      rank_cur  = init_rd_ff ? meta_rd_ff.rank : rank_reset();
      hit_way   = '0;
      free_way  = '0;
      lru_way   = '0;
      any_free  = 1'b0;
      for (int w = 0; w < WAYS; w++) begin
         hit_vec[w] = valid_cur[w] && (tags_rd_ff[w] == cur_ff.tag);
      end
      hit = |hit_vec;
      // scan down so the lowest way wins
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (hit_vec[w]) begin
            hit_way = WAY_BITS'(w);
         end
         if (!valid_cur[w]) begin
            free_way = WAY_BITS'(w);
            any_free = 1'b1;
         end
         if (rank_cur[w] == RANK_BITS'(WAYS - 1)) begin
            lru_way = WAY_BITS'(w);
         end
      end
      if (hit) begin
         way_sel = hit_way;
      end else if (any_free) begin
         way_sel = free_way;
      end else begin
         way_sel = lru_way;
      end
      old_rank = rank_cur[way_sel];

      tags_in = tags_rd_ff;
      meta_in.valid = valid_cur;
      for (int w = 0; w < WAYS; w++) begin
         if (WAY_BITS'(w) == way_sel) begin
            meta_in.rank[w] = '0;
            meta_in.valid[w] = 1'b1;
            if (!hit) begin
               tags_in[w] = cur_ff.tag;
            end
         end else if (rank_cur[w] < old_rank) begin
            meta_in.rank[w] = rank_cur[w] + RANK_BITS'(1);
         end else begin
            meta_in.rank[w] = rank_cur[w];
         end
         rank0_vec[w] = (meta_in.rank[w] == '0);
      end

      hit_count_in  = hit_count_ff;
      miss_count_in = miss_count_ff;
      if (hit) begin
         if (hit_count_ff != '1) begin
            hit_count_in = hit_count_ff + COUNT_BITS'(1);
         end
      end else begin
         if (miss_count_ff != '1) begin
            miss_count_in = miss_count_ff + COUNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         hit_count_ff  <= '0;
         miss_count_ff <= '0;
      end else begin
         if (rsp_valid_ff && rsp_ready && !commit) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (pop_valid) begin
                  cur_ff   <= pop_data;
                  state_ff <= ST_RESOLVE;
               end
            end
            ST_RESOLVE: begin
               // hold the read data until the output register frees up
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_hit_ff    <= hit;
                  rsp_way_ff    <= OUT_WAY_BITS'(way_sel);
                  hit_count_ff  <= hit_count_in;
                  miss_count_ff <= miss_count_in;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (pop_fire) begin
         tags_rd_ff <= tag_mem[pop_data.set_idx];
         meta_rd_ff <= meta_mem[pop_data.set_idx];
      end
      if (commit) begin
         tag_mem[cur_ff.set_idx]  <= tags_in;
         meta_mem[cur_ff.set_idx] <= meta_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SETS; s++) begin
            row_init_ff[s] <= 1'b0;
         end
         init_rd_ff <= 1'b0;
      end else begin
         if (pop_fire) begin
            init_rd_ff <= row_init_ff[pop_data.set_idx];
         end
         if (commit) begin
            row_init_ff[cur_ff.set_idx] <= 1'b1;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_way_used   = rsp_way_ff;
   assign rsp_hit_count  = hit_count_ff;
   assign rsp_miss_count = miss_count_ff;

   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESOLVE) |-> $onehot0(hit_vec))
      else $error("tag matches more than one valid way");

   a_one_mru: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESOLVE) |-> $onehot(rank0_vec))
      else $error("updated ranks do not have exactly one most recent way");

   a_rsp_from_resolve: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESOLVE))
      else $error("result raised outside resolve");

   a_hit_count_mono: assert property (@(posedge clock) disable iff (reset)
      !reset |=> (hit_count_ff >= $past(hit_count_ff)))
      else $error("hit count went down");

endmodule

[src/set_assoc_cache_lru_lookup.sv]
// channel  | direction | ports                                   | beat
// req      | in        | req_valid, req_ready, req_address       | one byte address
// rsp      | out       | rsp_valid, rsp_ready, rsp_hit,          | one lookup result
//          |           | rsp_way_used, rsp_hit_count, rsp_miss_count |
//
// In the back end, ST_IDLE reads the set's tag and rank row from RAM and ST_RESOLVE
// compares, picks the way, writes the row back and loads the result; no new address
// is taken until ST_RESOLVE is done. With no stalls a beat passes the front register,
// the queue, the RAM read and resolve before rsp_valid rises. A two-entry queue lets the
// front keep taking beats while the back waits on rsp_ready. Reset clears all per-set
// row flags; no clearing pass is needed, an unwritten set reads as all invalid.
module set_assoc_cache_lru_lookup (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [47:0] req_address,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_hit,
   output logic [2:0]  rsp_way_used,
   output logic [31:0] rsp_hit_count,
   output logic [31:0] rsp_miss_count
);
   import salru_pkg::*;

   logic          push_valid;
   logic          push_ready;
   salru_req_type push_data;
   logic          pop_valid;
   logic          pop_ready;
   salru_req_type pop_data;

   salru_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_address (req_address),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_data   (push_data)
   );

   salru_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   salru_back u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_data       (pop_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hit        (rsp_hit),
      .rsp_way_used   (rsp_way_used),
      .rsp_hit_count  (rsp_hit_count),
      .rsp_miss_count (rsp_miss_count)
   );

endmodule

[tb/tb_set_assoc_cache_lru_lookup.sv]
`timescale 1ns / 1ps

module tb_set_assoc_cache_lru_lookup;
   import salru_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES = 20;
   localparam int RANDOM_LOOKUPS = 720;
   localparam int TAG_POOL_SIZE = 12;

   typedef logic [ADDR_BITS-1:0] address_type;
   typedef logic [LINE_OFFSET_BITS-1:0] offset_type;

   typedef struct {
      logic        hit;
      logic [2:0]  way;
      logic [31:0] hits;
      logic [31:0] misses;
   } lookup_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   address_type req_address = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_hit;
   logic [2:0]  rsp_way_used;
   logic [31:0] rsp_hit_count;
   logic [31:0] rsp_miss_count;

   // shadow tag store
   logic          way_valid [SETS][WAYS];
   salru_tag_type way_tag [SETS][WAYS];
   salru_way_type way_rank [SETS][WAYS];
   logic [31:0]   hit_total;
   logic [31:0]   miss_total;

   lookup_result_type pending_lookups [$];

   int mismatch_count = 0;
   int lookups_sent = 0;
   int eviction_count = 0;
   int burst_left = 0;
   int hold_seq = 0;
   int idle_cycles = 0;

   salru_set_type hot_sets [4];
   salru_tag_type tag_pool [TAG_POOL_SIZE];

   set_assoc_cache_lru_lookup u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_address    (req_address),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hit        (rsp_hit),
      .rsp_way_used   (rsp_way_used),
      .rsp_hit_count  (rsp_hit_count),
      .rsp_miss_count (rsp_miss_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic address_type make_address(salru_tag_type tag, salru_set_type set_idx,
                                                offset_type offset);
      return {tag, set_idx, offset};
   endfunction

   function automatic void clear_tag_store();
      for (int s = 0; s < SETS; s++) begin
         for (int w = 0; w < WAYS; w++) begin
            way_valid[s][w] = 1'b0;
            way_tag[s][w] = '0;
            way_rank[s][w] = salru_way_type'(w);
         end
      end
      hit_total = '0;
      miss_total = '0;
   endfunction

   // look the address up in the shadow store, update it and queue the result
   function automatic void predict_lookup(address_type addr);
      salru_set_type s;
      salru_tag_type t;
      salru_way_type old_rank;
      lookup_result_type res;
      int way;
      logic found;
      s = addr[LINE_OFFSET_BITS +: SET_BITS];
      t = addr[ADDR_BITS-1 -: TAG_BITS];
      way = 0;
      found = 1'b0;
      for (int w = 0; w < WAYS; w++) begin
         if (!found && way_valid[s][w] && way_tag[s][w] == t) begin
            found = 1'b1;
            way = w;
         end
      end
      if (found) begin
         if (hit_total != '1) hit_total++;
      end else begin
         logic free_found;
         if (miss_total != '1) miss_total++;
         free_found = 1'b0;
         for (int w = 0; w < WAYS; w++) begin
            if (!free_found && !way_valid[s][w]) begin
               free_found = 1'b1;
               way = w;
            end
         end
         if (!free_found) begin
            eviction_count++;
            for (int w = 0; w < WAYS; w++) begin
               if (way_rank[s][w] == salru_way_type'(WAYS - 1)) way = w;
            end
         end
         way_valid[s][way] = 1'b1;
         way_tag[s][way] = t;
      end
      // age the ways younger than the touched one, then make it most recent
      old_rank = way_rank[s][way];
      for (int w = 0; w < WAYS; w++) begin
         if (way_rank[s][w] < old_rank) way_rank[s][w]++;
      end
      way_rank[s][way] = '0;
      res.hit = found;
      res.way = 3'(way);
      res.hits = hit_total;
      res.misses = miss_total;
      pending_lookups.push_back(res);
   endfunction

   task automatic send_address(address_type addr);
      req_valid <= 1'b1;
      req_address <= addr;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_lookup(addr);
      lookups_sent++;
   endtask

   // bursts of random length, random gaps between them
   task automatic paced_send(address_type addr);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      send_address(addr);
   endtask

   function automatic address_type random_full_address();
      return address_type'({$urandom, $urandom});
   endfunction

   function automatic address_type hot_address();
      return make_address(tag_pool[$urandom_range(0, TAG_POOL_SIZE - 1)],
                          hot_sets[$urandom_range(0, 3)],
                          offset_type'($urandom));
   endfunction

   task automatic test_address_extremes();
      paced_send('0);
      paced_send('1);
      paced_send('0);
      paced_send(address_type'(2 ** LINE_OFFSET_BITS - 1));
      paced_send(~address_type'(2 ** LINE_OFFSET_BITS - 1));
   endtask

   // fill one set, touch two ways, then evict in LRU order
   task automatic test_fill_and_evict();
      salru_set_type s;
      s = salru_set_type'(5);
      for (int i = 0; i < WAYS; i++) begin
         paced_send(make_address(salru_tag_type'(100 + i), s, offset_type'($urandom)));
      end
      paced_send(make_address(salru_tag_type'(102), s, '0));
      paced_send(make_address(salru_tag_type'(100), s, '0));
      paced_send(make_address(salru_tag_type'(200), s, '1));
      paced_send(make_address(salru_tag_type'(201), s, '0));
      paced_send(make_address(salru_tag_type'(101), s, '0));
      paced_send(make_address(salru_tag_type'(102), s, '0));
      paced_send(make_address(salru_tag_type'(200), s, '0));
   endtask

   // mostly a hot working set larger than one set, with random addresses mixed in
   task automatic test_random_traffic();
      int pick;
      for (int i = 0; i < RANDOM_LOOKUPS; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 75)
            paced_send(hot_address());
         else if (pick < 85)
            paced_send(make_address(tag_pool[$urandom_range(0, TAG_POOL_SIZE - 1)],
                                    salru_set_type'($urandom), offset_type'($urandom)));
         else
            paced_send(random_full_address());
      end
   endtask

   // stall the result side for a long stretch while lookups keep coming
   task automatic test_backpressure();
      hold_seq <= hold_seq + 1;
      for (int i = 0; i < 40; i++) begin
         send_address(hot_address());
      end
   endtask

   // result side: random stall pattern, re-picked as rsp_cycle advances; long hold-off on request
   int rsp_cycle = 0;
   int rsp_mode = 0;
   int hold_left = 0;
   int hold_done = 0;
   always @(posedge clock) begin
      rsp_cycle <= rsp_cycle + 1;
      if (rsp_cycle % 64 == 0) rsp_mode <= $urandom_range(0, 3);
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_seq != hold_done) begin
         hold_done <= hold_seq;
         hold_left <= HOLD_OFF_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         case (rsp_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= rsp_cycle[2];
         endcase
      end
   end

   always @(posedge clock) begin : check_results
      lookup_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_lookups.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result beat: hit=%0b way=%0d hits=%0d misses=%0d",
                        rsp_hit, rsp_way_used, rsp_hit_count, rsp_miss_count);
         end else begin
            want = pending_lookups.pop_front();
            if (rsp_hit !== want.hit || rsp_way_used !== want.way ||
                rsp_hit_count !== want.hits || rsp_miss_count !== want.misses) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch: expected hit=%0b way=%0d hits=%0d misses=%0d,",
                           want.hit, want.way, want.hits, want.misses);
                  $display("          got hit=%0b way=%0d hits=%0d misses=%0d",
                           rsp_hit, rsp_way_used, rsp_hit_count, rsp_miss_count);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                     idle_cycles, pending_lookups.size());
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      clear_tag_store();
      for (int i = 0; i < 4; i++) hot_sets[i] = salru_set_type'($urandom);
      hot_sets[0] = '0;
      hot_sets[1] = '1;
      for (int i = 0; i < TAG_POOL_SIZE; i++) tag_pool[i] = salru_tag_type'({$urandom, $urandom});
      tag_pool[0] = '0;
      tag_pool[1] = '1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_address_extremes();
      test_fill_and_evict();
      test_backpressure();
      test_random_traffic();

      req_valid <= 1'b0;
      while (pending_lookups.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("ran %0d lookups: %0d hits, %0d misses, %0d evictions from full sets",
               lookups_sent, hit_total, miss_total, eviction_count);
      $display("%0d mismatches, %0d results left over", mismatch_count,
               pending_lookups.size());
      if (mismatch_count == 0 && pending_lookups.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
